@@ rtl/core/assert_macros.svh @@
// assertion macros used by the checker file b64_checker
// no dependencies; expects clk_i and rst_ni in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, off while reset is held
`define B64_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// concurrent assertion, checked during reset as well
`define B64_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/core/b64_pkg.sv @@
// shared types, constants and the alphabet lookup of the base64 encoder
// no dependencies
`default_nettype none

package b64_pkg;

  // depth of the group queue between front and back, a power of two
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(QDEPTH + 1);

  localparam logic [5:0] MASK6 = 6'h3F;

  typedef logic [1:0] idx_t;

  // one completed or flushed group of up to three bytes
  typedef struct packed {
    logic [23:0] bits;      // first byte in the top byte, missing bits zero
    idx_t        last_idx;  // index of the last character to emit
    logic        fin;       // group ends the message
  } group_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic   valid;
    group_t grp;
  } head_t;

  // standard alphabet: A-Z a-z 0-9 + /
  function automatic logic [6:0] sextet_char(input logic [5:0] s);
    logic [5:0] v;
    logic [6:0] c;
    begin
      v = s & MASK6;
      if (v < 6'd26) begin
        c = 7'd65 + {1'b0, v};
      end else if (v < 6'd52) begin
        c = 7'd71 + {1'b0, v};
      end else if (v < 6'd62) begin
        c = {1'b0, v} - 7'd4;
      end else if (v == 6'd62) begin
        c = 7'd43;
      end else begin
        c = 7'd47;
      end
      return c;
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/b64_front.sv @@
// front end: collects bytes and forms groups for the queue
// depends on b64_pkg
`default_nettype none

module b64_front
  import b64_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       final_byte_i,
  output logic            push_o,
  output group_t          push_grp_o,
  input  wire logic       push_ready_i
);

  logic [15:0] held_q, held_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        accept;
  logic        full_grp;

  // a count of three never occurs; bit 1 treats it as two
  assign full_grp   = cnt_q[1];
  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && (full_grp || final_byte_i);

  always_comb begin
    held_d     = held_q;
    cnt_d      = cnt_q;
    push_grp_o = '0;
    if (full_grp) begin
      push_grp_o.bits     = {held_q, data_byte_i};
      push_grp_o.last_idx = idx_t'(3);
      push_grp_o.fin      = final_byte_i;
    end else if (cnt_q[0]) begin
      push_grp_o.bits     = {held_q[7:0], data_byte_i, 8'h00};
      push_grp_o.last_idx = idx_t'(2);
      push_grp_o.fin      = 1'b1;
    end else begin
      push_grp_o.bits     = {data_byte_i, 16'h0000};
      push_grp_o.last_idx = idx_t'(1);
      push_grp_o.fin      = 1'b1;
    end
    if (accept) begin
      if (full_grp || final_byte_i) begin
        held_d = '0;
        cnt_d  = '0;
      end else begin
        held_d = {held_q[7:0], data_byte_i};
        cnt_d  = cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      cnt_q  <= '0;
    end else begin
      held_q <= held_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/b64_queue.sv @@
// short group queue between the front and back ends
// depends on b64_pkg
`default_nettype none

module b64_queue
  import b64_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  group_t      push_grp_i,
  output logic        push_ready_o,
  output head_t       head_o,
  input  wire logic   pop_i
);

  group_t             entry_q [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               do_push, do_pop;

  assign push_ready_o = (cnt_q != CNT_W'(QDEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.grp   = entry_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && head_o.valid;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_grp_i;
    end
  end

  // pointers wrap naturally, depth is a power of two
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/b64_back.sv @@
// back end: emits one character a cycle from the queue head while a group is queued and the receiver is ready
// depends on b64_pkg
`default_nettype none

module b64_back
  import b64_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  head_t      head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output logic [6:0] out_char_o,
  output logic       msg_end_o
);

  idx_t       idx_q, idx_d;
  logic       valid_q;
  logic [6:0] char_q;
  logic       end_q;
  logic       load;
  logic       last;
  logic [5:0] sextet;

  assign load  = head_i.valid && (!valid_q || out_ready_i);
  assign last  = (idx_q == head_i.grp.last_idx);
  assign pop_o = load && last;

  always_comb begin
    case (idx_q)
      2'd0:    sextet = head_i.grp.bits[23:18];
      2'd1:    sextet = head_i.grp.bits[17:12];
      2'd2:    sextet = head_i.grp.bits[11:6];
      default: sextet = head_i.grp.bits[5:0];
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = last ? '0 : idx_q + idx_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= sextet_char(sextet);
      end_q  <= head_i.grp.fin && last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign msg_end_o   = end_q;

endmodule

`default_nettype wire

@@ rtl/core/base64_stream_encoder.sv @@
// unpadded base64 encoder, one byte in and one character out per beat
// the closing byte's group is written into the queue, then its first character into the output register
// throughput: one character a cycle while the receiver is ready and a group is queued;
//   bytes are taken once a cycle while the two-group queue has room
// reset: asynchronous active low, empties the byte holder, the queue and the output
// depends on b64_pkg, b64_front, b64_queue, b64_back
`default_nettype none

module base64_stream_encoder
  import b64_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // byte channel
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       final_byte_i,
  // character channel
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [6:0]      out_char_o,
  output logic            msg_end_o
);

  // front to queue: completed or flushed groups
  logic   push;
  group_t push_grp;
  logic   push_ready;

  // queue to back: head group, popped after its last character
  head_t  head;
  logic   pop;

  // front holds up to two bytes, pushes a group on a third byte or the final one
  b64_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .push_o       (push),
    .push_grp_o   (push_grp),
    .push_ready_i (push_ready)
  );

  // decouples byte intake from character output so each side stalls alone
  b64_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_grp_i   (push_grp),
    .push_ready_o (push_ready),
    .head_o       (head),
    .pop_i        (pop)
  );

  // walks the head group a sextet at a time into the output register
  b64_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .msg_end_o   (msg_end_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/b64_checker.sv @@
// port-level checks of the base64 encoder, bound to the top level
// depends on assert_macros.svh and base64_stream_encoder
`default_nettype none
`include "assert_macros.svh"

module b64_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic [7:0] data_byte_i,
  input wire logic       final_byte_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [6:0] out_char_o,
  input wire logic       msg_end_o
);

  logic out_stall;
  logic in_alpha;

  assign out_stall = out_valid_o && !out_ready_i;
  assign in_alpha  = (out_char_o == 7'd43) || (out_char_o == 7'd47) ||
                     (out_char_o >= 7'd48 && out_char_o <= 7'd57) ||
                     (out_char_o >= 7'd65 && out_char_o <= 7'd90) ||
                     (out_char_o >= 7'd97 && out_char_o <= 7'd122);

  // a stalled character stays put
  `B64_ASSERT(a_out_hold, out_stall |=> out_valid_o && $stable({out_char_o, msg_end_o}), "stalled character changed")

  // only characters of the alphabet leave the block
  `B64_ASSERT(a_charset, out_valid_o |-> in_alpha, "character outside alphabet")

  // no character is offered once reset has been seen at an edge
  `B64_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o, "output valid in reset")

  // nothing is waiting at the output straight after reset
  `B64_ASSERT(a_idle_after_reset, $rose(rst_ni) |-> !out_valid_o, "output valid after reset")

endmodule

bind base64_stream_encoder b64_checker u_b64_checker (.*);

`default_nettype wire

@@ tb/base64_stream_encoder_test.sv @@
// self-checking testbench for the unpadded base64 stream encoder
// holds its own encoder model and compares every output character against it
// depends only on the rtl top level base64_stream_encoder
`default_nettype none

module base64_stream_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  // receiver hold-off long enough to fill the group queue and stall the byte side
  localparam int HOLD_CYCLES    = 150;
  // cycles without any beat before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;
  // extra cycles after the last expected character
  localparam int TAIL_CYCLES    = 12;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_BYTES   = 290;

  // standard alphabet, index is the sextet value
  localparam string CHARSET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // one expected character beat
  typedef struct packed {
    logic [6:0] ch;
    logic       mark;
  } b64_char_t;

  // stimulus side, known from time zero
  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic [7:0] data_byte_i  = 8'h00;
  logic       final_byte_i = 1'b0;
  logic       out_ready_i  = 1'b0;

  wire logic       in_ready_o;
  wire logic       out_valid_o;
  wire logic [6:0] out_char_o;
  wire logic       msg_end_o;

  // characters still owed by the block, oldest first
  b64_char_t exp_chars[$];

  // model state: bytes waiting for a full group, newest in the low byte
  logic [15:0] pend_bytes = 16'h0000;
  logic [1:0]  pend_count = 2'd0;

  int bytes_sent    = 0;
  int msgs_sent     = 0;
  int chars_checked = 0;
  int errors        = 0;
  int idle_cnt      = 0;

  // sender idling is local to the stimulus process
  bit src_idle_en  = 1'b1;
  // receiver controls, written with nonblocking assignments from the stimulus
  bit sink_idle_en = 1'b1;
  int hold_reqs    = 0;
  int hold_served  = 0;
  int hold_left    = 0;

  base64_stream_encoder DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_char_o   (out_char_o),
    .msg_end_o    (msg_end_o)
  );

  // 2 ns period
  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // encoder model
  // ---------------------------------------------------------------------------

  function automatic logic [6:0] char_of(input logic [5:0] s);
    byte c;
    c = CHARSET[s];
    return c[6:0];
  endfunction

  // queue the leading nchars sextets of a group, most significant first;
  // only the very last character of a message carries the end mark
  task automatic push_group(input logic [23:0] grp, input int nchars, input logic fin);
    b64_char_t c;
    for (int k = 0; k < nchars; k++) begin
      c.ch   = char_of(grp[23 - 6 * k -: 6]);
      c.mark = fin && (k == nchars - 1);
      exp_chars.push_back(c);
    end
  endtask

  task automatic predict_encoding(input logic [7:0] b, input logic fin);
    if (pend_count >= 2'd2) begin
      // third byte closes a group: four characters, end mark only if final
      push_group({pend_bytes, b}, 4, fin);
      pend_bytes = 16'h0000;
      pend_count = 2'd0;
    end else if (fin) begin
      // partial group flushed with zero fill and no padding
      if (pend_count == 2'd1) begin
        push_group({pend_bytes[7:0], b, 8'h00}, 3, 1'b1);
      end else begin
        push_group({b, 16'h0000}, 2, 1'b1);
      end
      pend_bytes = 16'h0000;
      pend_count = 2'd0;
    end else begin
      pend_bytes = {pend_bytes[7:0], b};
      pend_count = pend_count + 2'd1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // byte side
  // ---------------------------------------------------------------------------

  // entered just after a rising edge; returns at the edge that took the beat.
  // valid is left high so a back-to-back byte needs only a payload change
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (src_idle_en && ($urandom_range(0, 99) < 28)) begin
      in_valid_i <= 1'b0;
      do begin
        @(posedge clk_i);
        idle_cnt++;
      end while ($urandom_range(0, 99) < 28);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    final_byte_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    predict_encoding(b, fin);
    bytes_sent++;
    if (fin) msgs_sent++;
  endtask

  // bias towards all-zero and all-one bytes to hit the alphabet ends often
  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic send_random_message();
    int len;
    if ($urandom_range(0, 9) == 0) len = $urandom_range(10, 30);
    else len = $urandom_range(1, 9);
    for (int i = 0; i < len; i++) begin
      send_byte(pick_byte(), i == len - 1);
    end
  endtask

  // sender steps back until every owed character has been seen
  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (exp_chars.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // character side
  // ---------------------------------------------------------------------------

  // receiver: a requested hold-off runs for a counted stretch, otherwise
  // ready is random at about 28 percent idling or held high
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (hold_reqs != hold_served) begin
      hold_served <= hold_reqs;
      hold_left   <= HOLD_CYCLES - 1;
      out_ready_i <= 1'b0;
    end else if (sink_idle_en) begin
      out_ready_i <= ($urandom_range(0, 99) >= 28);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // compare each character beat with the oldest expectation
  always @(posedge clk_i) begin : char_check
    b64_char_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      chars_checked++;
      if (exp_chars.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("[%0t] unexpected character 0x%02h end=%0b", $realtime,
                   out_char_o, msg_end_o);
      end else begin
        want = exp_chars.pop_front();
        if ((want.ch !== out_char_o) || (want.mark !== msg_end_o)) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("[%0t] mismatch: char exp 0x%02h got 0x%02h, end exp %0b got %0b",
                     $realtime, want.ch, out_char_o, want.mark, msg_end_o);
        end
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d characters still owed",
                 WATCHDOG_LIMIT, exp_chars.size());
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // final byte with nothing held: two characters, the second marked
  task automatic test_single_byte_messages();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hA5, 1'b1);
  endtask

  // one byte held then the final byte: three characters
  task automatic test_two_byte_messages();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // final byte closing a full group: the fourth character carries the end mark
  task automatic test_group_closing_final();
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    // every sextet 62, all plus signs
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b1);
  endtask

  // full unmarked groups followed by a short tail
  task automatic test_open_group_then_tail();
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b0);
    send_byte(8'h69, 1'b0);
    send_byte(8'hB7, 1'b0);
    send_byte(8'h1D, 1'b0);
    send_byte(8'h21, 1'b1);
  endtask

  // random messages; the middle third runs with no idling on either side
  task automatic test_random_messages();
    int start;
    start = bytes_sent;
    while (bytes_sent < start + RANDOM_BYTES) begin
      if (bytes_sent < start + RANDOM_BYTES / 3) begin
        src_idle_en = 1'b1;
      end else if (bytes_sent < start + 2 * RANDOM_BYTES / 3) begin
        if (src_idle_en) sink_idle_en <= 1'b0;
        src_idle_en = 1'b0;
      end else begin
        if (!src_idle_en) sink_idle_en <= 1'b1;
        src_idle_en = 1'b1;
      end
      send_random_message();
    end
    src_idle_en = 1'b1;
  endtask

  // receiver holds off while bytes keep coming, so the queue fills and
  // the byte side must stall until characters drain again
  task automatic test_input_backpressure();
    int start;
    start = bytes_sent;
    src_idle_en = 1'b0;
    sink_idle_en <= 1'b0;
    hold_reqs <= hold_reqs + 1;
    while (bytes_sent < start + 60) send_random_message();
    src_idle_en = 1'b1;
    sink_idle_en <= 1'b1;
  endtask

  // sender pauses with the block fully drained, also mid-message
  task automatic test_sender_drain_pause();
    for (int m = 0; m < 6; m++) begin
      send_random_message();
      pause_until_drained();
      send_byte(pick_byte(), 1'b0);
      pause_until_drained();
      send_byte(pick_byte(), 1'b1);
      pause_until_drained();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_byte_messages();
    test_two_byte_messages();
    test_group_closing_final();
    test_open_group_then_tail();
    test_random_messages();
    test_input_backpressure();
    test_sender_drain_pause();

    // let the last characters through, then a short tail for strays
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (exp_chars.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("encoded %0d bytes in %0d messages, checked %0d characters",
             bytes_sent, msgs_sent, chars_checked);
    $display("sender idle cycles %0d, receiver hold-offs %0d, errors %0d",
             idle_cnt, hold_served, errors);
    if ((errors == 0) && (exp_chars.size() == 0)) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+rtl/core
rtl/core/b64_pkg.sv
rtl/core/b64_front.sv
rtl/core/b64_queue.sv
rtl/core/b64_back.sv
rtl/core/base64_stream_encoder.sv
rtl/core/b64_checker.sv
tb/base64_stream_encoder_test.sv
